// ===== hdl/istat_pkg.sv =====
// shared types, constants and lookup tables of the image statistics accumulator
package istat_pkg;

	// command codes
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ACCUM = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// statistic word map
	localparam logic [8:0] IDX_CHAN_SUM = 9'd256;
	localparam logic [8:0] IDX_SAT_SUM  = 9'd259;
	localparam logic [8:0] IDX_NEU_BYTE = 9'd260;
	localparam logic [8:0] IDX_NEU_LIN  = 9'd263;
	localparam logic [8:0] IDX_NEU_TOT  = 9'd266;
	localparam logic [8:0] IDX_POW6     = 9'd267;
	localparam logic [8:0] IDX_PIX_TOT  = 9'd270;

	// luma weights in q16 (luma * 255)
	localparam logic [23:0] LUMA_WR = 24'd13933;
	localparam logic [23:0] LUMA_WG = 24'd46871;
	localparam logic [23:0] LUMA_WB = 24'd4732;

	// luma window limits
	localparam logic [23:0] NEU_LUMA_LO = 24'd1671168;
	localparam logic [23:0] NEU_LUMA_HI = 24'd15040512;
	localparam logic [23:0] MID_LUMA_LO = 24'd334233;
	localparam logic [23:0] MID_LUMA_HI = 24'd16544564;

	// saturation limit: (max-min)*100 <= 22*max
	localparam logic [14:0] SAT_SCALE = 15'd100;
	localparam logic [14:0] SAT_LIMIT = 15'd22;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int HIST_W = 21;
	localparam int BYTE_SUM_W = 28;
	localparam int SAT_SUM_W = 37;
	localparam int LIN_SUM_W = 37;
	localparam int POW6_SUM_W = 61;
	localparam int LIN_W = 17;
	localparam int POW6_W = 41;
	localparam int SAT_W = 17;
	localparam int RECIP_W = 33;

	typedef logic [255:0][LIN_W-1:0] lin_rom_t;
	typedef logic [255:0][POW6_W-1:0] pow6_rom_t;
	typedef logic [255:0][RECIP_W-1:0] recip_rom_t;

	// classified request from front to back
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [8:0] addr;
		logic [SAT_W-1:0] sat;
		logic neutral;
		logic mid;
	} istat_op_t;

	// srgb byte to linear light in q31
	function automatic logic [31:0] lin_q31(input int unsigned b);
		logic [63:0] u;
		logic [63:0] s;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] t;
		int k;
		int j;
		if (b <= 10) begin
			return 32'(((64'(b) * 64'd5) << 31) / 64'd16473);
		end
		u = ((64'(b) * 64'd1000 + 64'd14025) << 31) / 64'd269025;
		if (u > (64'd1 << 31)) begin
			u = 64'd1 << 31;
		end
		s = (u * u) >> 31;
		lo = '0;
		hi = 64'd1 << 31;
		for (k = 0; k < 40; k++) begin
			if (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				t = mid;
				for (j = 0; j < 4; j++) begin
					t = (t * mid) >> 31;
				end
				if (t <= s) begin
					lo = mid;
				end else begin
					hi = mid - 64'd1;
				end
			end
		end
		return 32'((s * lo) >> 31);
	endfunction

	// q16 linear table, rounded half up
	function automatic lin_rom_t build_lin_rom();
		lin_rom_t r;
		logic [31:0] a;
		for (int i = 0; i < 256; i++) begin
			a = lin_q31(i);
			r[i] = LIN_W'((64'(a) + 64'd16384) >> 15);
		end
		return r;
	endfunction

	// q40 linear^6 table
	function automatic pow6_rom_t build_pow6_rom();
		pow6_rom_t r;
		logic [31:0] a;
		logic [127:0] x;
		logic [127:0] c;
		for (int i = 0; i < 256; i++) begin
			a = lin_q31(i);
			x = 128'(a) * 128'(a) * 128'(a);
			c = x >> 33;
			r[i] = POW6_W'((c * c) >> 80);
		end
		return r;
	endfunction

	// ceil(2^32 / m) by restoring long division, zero for m of zero
	function automatic recip_rom_t build_recip_rom();
		recip_rom_t r;
		logic [33:0] rem;
		logic [32:0] q;
		logic [32:0] num;
		num = 33'd1 << 32;
		r[0] = '0;
		for (int m = 1; m < 256; m++) begin
			rem = '0;
			q = '0;
			for (int k = 32; k >= 0; k--) begin
				rem = {rem[32:0], num[k]};
				if (rem >= 34'(m)) begin
					rem = rem - 34'(m);
					q[k] = 1'b1;
				end
			end
			if (rem != '0) begin
				q = q + 33'd1;
			end
			r[m] = q;
		end
		return r;
	endfunction

	localparam lin_rom_t LIN_ROM = build_lin_rom();
	localparam pow6_rom_t POW6_ROM = build_pow6_rom();
	localparam recip_rom_t RECIP_ROM = build_recip_rom();

endpackage

// ===== hdl/istat_if.sv =====
// request and response channel interfaces
interface istat_req_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [8:0] read_index;
	modport source (output valid, cmd, red, green, blue, read_index, input ready);
	modport sink (input valid, cmd, red, green, blue, read_index, output ready);
endinterface

interface istat_rsp_if;
	logic valid;
	logic ready;
	logic [60:0] read_data;
	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface

// ===== hdl/istat_front.sv =====
// front end: takes requests, computes luma, saturation and pixel class
module istat_front import istat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	istat_req_if.sink req,
	output istat_op_t op,
	output logic op_valid,
	input  logic op_full
);

	logic valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] red_s1, green_s1, blue_s1;
	logic [8:0] idx_s1;

	logic valid_s2;
	logic [1:0] cmd_s2;
	logic [7:0] red_s2, green_s2, blue_s2;
	logic [8:0] idx_s2;
	logic [23:0] luma_s2;
	logic [7:0] max_s2, min_s2;

	logic adv1, adv2;
	logic known_cmd;
	logic [23:0] luma_c;
	logic [7:0] max_c, min_c;
	logic [7:0] diff;
	logic [40:0] sat_prod;
	logic sat_ok;

	// stall control
	assign adv2 = !valid_s2 || !op_full;
	assign adv1 = !valid_s1 || adv2;
	assign req.ready = adv1;
	assign known_cmd = (req.cmd == CMD_CLEAR) || (req.cmd == CMD_ACCUM) ||
		(req.cmd == CMD_READ);

	// luma and channel extremes
	always_comb begin
		luma_c = 24'(red_s1) * LUMA_WR + 24'(green_s1) * LUMA_WG + 24'(blue_s1) * LUMA_WB;
		max_c = red_s1;
		min_c = red_s1;
		if (green_s1 > max_c) max_c = green_s1;
		if (blue_s1 > max_c) max_c = blue_s1;
		if (green_s1 < min_c) min_c = green_s1;
		if (blue_s1 < min_c) min_c = blue_s1;
	end

	// saturation by reciprocal and pixel class
	always_comb begin
		diff = max_s2 - min_s2;
		sat_prod = 41'(diff) * 41'(RECIP_ROM[max_s2]);
		sat_ok = (15'(diff) * SAT_SCALE) <= (15'(max_s2) * SAT_LIMIT);
		op.cmd = cmd_s2;
		op.red = red_s2;
		op.green = green_s2;
		op.blue = blue_s2;
		op.addr = (cmd_s2 == CMD_READ) ? idx_s2 : {1'b0, luma_s2[23:16]};
		op.sat = sat_prod[32:16];
		op.neutral = sat_ok && (luma_s2 > NEU_LUMA_LO) && (luma_s2 < NEU_LUMA_HI);
		op.mid = (luma_s2 > MID_LUMA_LO) && (luma_s2 < MID_LUMA_HI);
	end
	assign op_valid = valid_s2;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= req.valid && known_cmd;
			if (adv2) valid_s2 <= valid_s1;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv1) begin
			cmd_s1 <= req.cmd;
			red_s1 <= req.red;
			green_s1 <= req.green;
			blue_s1 <= req.blue;
			idx_s1 <= req.read_index;
		end
		if (adv2) begin
			cmd_s2 <= cmd_s1;
			red_s2 <= red_s1;
			green_s2 <= green_s1;
			blue_s2 <= blue_s1;
			idx_s2 <= idx_s1;
			luma_s2 <= luma_c;
			max_s2 <= max_c;
			min_s2 <= min_c;
		end
	end

endmodule

// ===== hdl/istat_queue.sv =====
// request queue between front and back, depth a power of two
module istat_queue import istat_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  istat_op_t wr_op,
	input  logic wr_valid,
	output logic full,
	output istat_op_t rd_op,
	output logic rd_valid,
	input  logic rd_pop
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	istat_op_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_op = mem_q[rd_ptr_q];
	assign push = wr_valid && !full;
	assign pop = rd_pop && rd_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_op;
	end

endmodule

// ===== hdl/istat_back.sv =====
// back end: histogram memory, accumulators, word select and response buffer
module istat_back import istat_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  istat_op_t op,
	input  logic op_valid,
	output logic op_pop,
	istat_rsp_if.source rsp
);

	localparam int OUT_DEPTH = 4;

	// histogram memory with per-bin valid bits
	logic [HIST_W-1:0] hist_mem [256];
	logic [255:0] hist_vld_q;
	logic [HIST_W-1:0] hist_rd_s1;
	logic vld_rd_s1;

	// execute stage
	logic valid_b1;
	istat_op_t op_b1;
	logic [2:0][LIN_W-1:0] lin_b1;
	logic [2:0][POW6_W-1:0] pow6_b1;

	// forward of the previous execute cycle
	logic fwd_wr_q;
	logic fwd_clr_q;
	logic [7:0] fwd_addr_q;
	logic [HIST_W-1:0] fwd_data_q;

	// accumulators
	logic [2:0][BYTE_SUM_W-1:0] chan_sum_q;
	logic [SAT_SUM_W-1:0] sat_sum_q;
	logic [2:0][BYTE_SUM_W-1:0] neu_byte_q;
	logic [2:0][LIN_SUM_W-1:0] neu_lin_q;
	logic [HIST_W-1:0] neu_tot_q;
	logic [2:0][POW6_SUM_W-1:0] pow6_sum_q;
	logic [HIST_W-1:0] pix_tot_q;

	// response buffer
	logic [60:0] out_mem_q [OUT_DEPTH];
	logic [1:0] out_wr_q, out_rd_q;
	logic [2:0] out_cnt_q;

	logic is_acc, is_clr, is_rd;
	logic [HIST_W-1:0] bin_cur;
	logic [HIST_W-1:0] bin_next;
	logic [60:0] word;
	logic [7:0] pix [3];
	logic out_push, out_pop;

	assign is_acc = valid_b1 && (op_b1.cmd == CMD_ACCUM);
	assign is_clr = valid_b1 && (op_b1.cmd == CMD_CLEAR);
	assign is_rd = valid_b1 && (op_b1.cmd == CMD_READ);

	// take a request only when the response buffer has room for it
	assign op_pop = op_valid && ((4'(out_cnt_q) + 4'(is_rd)) < 4'(OUT_DEPTH));

	// current bin count with forwarding around the memory
	always_comb begin
		if (fwd_clr_q) bin_cur = '0;
		else if (fwd_wr_q && (fwd_addr_q == op_b1.addr[7:0])) bin_cur = fwd_data_q;
		else if (vld_rd_s1) bin_cur = hist_rd_s1;
		else bin_cur = '0;
		bin_next = bin_cur + HIST_W'(1);
	end

	// statistic word select
	always_comb begin
		word = '0;
		if (op_b1.addr < IDX_CHAN_SUM) word = 61'(bin_cur);
		else if (op_b1.addr < IDX_SAT_SUM) word = 61'(chan_sum_q[2'(op_b1.addr - IDX_CHAN_SUM)]);
		else if (op_b1.addr == IDX_SAT_SUM) word = 61'(sat_sum_q);
		else if (op_b1.addr < IDX_NEU_LIN) word = 61'(neu_byte_q[2'(op_b1.addr - IDX_NEU_BYTE)]);
		else if (op_b1.addr < IDX_NEU_TOT) word = 61'(neu_lin_q[2'(op_b1.addr - IDX_NEU_LIN)]);
		else if (op_b1.addr == IDX_NEU_TOT) word = 61'(neu_tot_q);
		else if (op_b1.addr < IDX_PIX_TOT) word = pow6_sum_q[2'(op_b1.addr - IDX_POW6)];
		else if (op_b1.addr == IDX_PIX_TOT) word = 61'(pix_tot_q);
	end

	assign pix[0] = op_b1.red;
	assign pix[1] = op_b1.green;
	assign pix[2] = op_b1.blue;

	// histogram memory read and write
	always_ff @(posedge clk) begin
		if (op_pop) hist_rd_s1 <= hist_mem[op.addr[7:0]];
		if (is_acc) hist_mem[op_b1.addr[7:0]] <= bin_next;
	end

	// execute stage payload and table lookups
	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_b1 <= op;
			lin_b1[0] <= LIN_ROM[op.red];
			lin_b1[1] <= LIN_ROM[op.green];
			lin_b1[2] <= LIN_ROM[op.blue];
			pow6_b1[0] <= POW6_ROM[op.red];
			pow6_b1[1] <= POW6_ROM[op.green];
			pow6_b1[2] <= POW6_ROM[op.blue];
		end
		fwd_addr_q <= op_b1.addr[7:0];
		fwd_data_q <= bin_next;
		if (out_push) out_mem_q[out_wr_q] <= word;
	end

	// control, valid bits and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1 <= 1'b0;
			vld_rd_s1 <= 1'b0;
			hist_vld_q <= '0;
			fwd_wr_q <= 1'b0;
			fwd_clr_q <= 1'b0;
			chan_sum_q <= '0;
			sat_sum_q <= '0;
			neu_byte_q <= '0;
			neu_lin_q <= '0;
			neu_tot_q <= '0;
			pow6_sum_q <= '0;
			pix_tot_q <= '0;
		end else begin
			valid_b1 <= op_pop;
			if (op_pop) vld_rd_s1 <= hist_vld_q[op.addr[7:0]];
			fwd_wr_q <= is_acc;
			fwd_clr_q <= is_clr;
			if (is_clr) begin
				hist_vld_q <= '0;
				chan_sum_q <= '0;
				sat_sum_q <= '0;
				neu_byte_q <= '0;
				neu_lin_q <= '0;
				neu_tot_q <= '0;
				pow6_sum_q <= '0;
				pix_tot_q <= '0;
			end else if (is_acc) begin
				hist_vld_q[op_b1.addr[7:0]] <= 1'b1;
				pix_tot_q <= pix_tot_q + HIST_W'(1);
				sat_sum_q <= sat_sum_q + SAT_SUM_W'(op_b1.sat);
				for (int c = 0; c < 3; c++) begin
					chan_sum_q[c] <= chan_sum_q[c] + BYTE_SUM_W'(pix[c]);
					if (op_b1.mid) pow6_sum_q[c] <= pow6_sum_q[c] + POW6_SUM_W'(pow6_b1[c]);
					if (op_b1.neutral) begin
						neu_byte_q[c] <= neu_byte_q[c] + BYTE_SUM_W'(pix[c]);
						neu_lin_q[c] <= neu_lin_q[c] + LIN_SUM_W'(lin_b1[c]);
					end
				end
				if (op_b1.neutral) neu_tot_q <= neu_tot_q + HIST_W'(1);
			end
		end
	end

	// response buffer
	assign out_push = is_rd;
	assign out_pop = rsp.valid && rsp.ready;
	assign rsp.valid = (out_cnt_q != '0);
	assign rsp.read_data = out_mem_q[out_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q <= '0;
			out_rd_q <= '0;
			out_cnt_q <= '0;
		end else begin
			if (out_push) out_wr_q <= out_wr_q + 2'd1;
			if (out_pop) out_rd_q <= out_rd_q + 2'd1;
			if (out_push && !out_pop) out_cnt_q <= out_cnt_q + 3'd1;
			else if (out_pop && !out_push) out_cnt_q <= out_cnt_q - 3'd1;
		end
	end

endmodule

// ===== hdl/image_statistics_accumulator.sv =====
// Luma histogram and gray-world statistics: one request per cycle sustained while the response buffer has a free entry.
// A read answer passes two front stages, the request queue, one execute stage with the
// histogram memory port, and the response buffer before it is shown.
// Throughput: 1 request per cycle; any request stalls while the 4-entry response
// buffer, counting a read in the execute stage, has no free entry.
// Reset: all statistics read as zero at once; histogram bins through per-bin valid bits.
module image_statistics_accumulator import istat_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	istat_req_if.sink req,
	istat_rsp_if.source rsp
);

	istat_op_t front_op;
	istat_op_t head_op;
	logic front_valid;
	logic queue_full;
	logic head_valid;
	logic head_pop;

	// classify requests
	istat_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.op(front_op),
		.op_valid(front_valid),
		.op_full(queue_full)
	);

	// decouple front and back
	istat_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_op(front_op),
		.wr_valid(front_valid),
		.full(queue_full),
		.rd_op(head_op),
		.rd_valid(head_valid),
		.rd_pop(head_pop)
	);

	// execute and answer
	istat_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.op(head_op),
		.op_valid(head_valid),
		.op_pop(head_pop),
		.rsp(rsp)
	);

endmodule
